>>> rtl/cds_pkg.sv
// Shared types and constants for the COO to diagonal storage converter.
// Used by cds_ctrl, cds_datapath and the top level coo_to_diagonal_storage.
package cds_pkg;

    localparam int FUNC_W   = 2;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int VALUE_W  = 64;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 7;
    localparam int COUNT_W  = 5;
    localparam int DIM_W    = 7;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 88;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    typedef enum logic [1:0] {
        FUNC_SCAN  = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_NOREG = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_ZERO = 2'd0,
        SLOT_REQ  = 2'd1,
        SLOT_IDX  = 2'd2
    } slot_sel_t;

    typedef enum logic [1:0] {
        OFF_ZERO = 2'd0,
        OFF_TRIP = 2'd1,
        OFF_TAB  = 2'd2
    } off_sel_t;

    typedef enum logic [1:0] {
        TRD_IDX   = 2'd0,
        TRD_SHIFT = 2'd1,
        TRD_REQ   = 2'd2
    } tab_rd_t;

    typedef enum logic {
        TWR_SHIFT  = 1'b0,
        TWR_INSERT = 1'b1
    } tab_wr_t;

    typedef struct packed {
        logic      in_load;
        logic      idx_clr;
        logic      idx_inc;
        logic      sh_load;
        logic      sh_dec;
        logic      tab_rd;
        tab_rd_t   tab_rd_src;
        logic      tab_wr;
        tab_wr_t   tab_wr_src;
        logic      cnt_inc;
        logic      clear;
        logic      entry_rd;
        logic      vw_rd;
        logic      ld_wr;
        logic      res_load;
        status_t   res_status;
        slot_sel_t slot_sel;
        off_sel_t  off_sel;
        logic      val_sel;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  row_err;
        logic  col_err;
        logic  req_bad;
        logic  full;
        logic  idx_at_count;
        logic  sh_at_idx;
        logic  tab_lt;
        logic  tab_eq;
        logic  out_busy;
    } stat_t;

endpackage

>>> rtl/cds_ctrl.sv
// Sequencer for the diagonal storage converter: decodes each item and steps
// the datapath through search, shift, store and result phases. Uses cds_pkg.
module cds_ctrl
    import cds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_LOAD_WR,
        ST_FIN
    } state_t;

    state_t    state_reg, state_next;
    status_t   res_status_reg, res_status_next;
    slot_sel_t slot_sel_reg, slot_sel_next;
    off_sel_t  off_sel_reg, off_sel_next;
    logic      val_sel_reg, val_sel_next;

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        slot_sel_next   = slot_sel_reg;
        off_sel_next    = off_sel_reg;
        val_sel_next    = val_sel_reg;
        cmd             = '0;
        cmd.res_status  = res_status_reg;
        cmd.slot_sel    = slot_sel_reg;
        cmd.off_sel     = off_sel_reg;
        cmd.val_sel     = val_sel_reg;
        in_ready        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                res_status_next = STAT_OK;
                slot_sel_next   = SLOT_ZERO;
                off_sel_next    = OFF_ZERO;
                val_sel_next    = 1'b0;
                case (stat.func)
                    FUNC_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_FIN;
                    end
                    FUNC_READ:
                    begin
                        state_next = ST_FIN;
                        if (stat.row_err)
                        begin
                            res_status_next = STAT_RANGE;
                        end
                        else if (stat.req_bad)
                        begin
                            res_status_next = STAT_NOREG;
                            slot_sel_next   = SLOT_REQ;
                        end
                        else
                        begin
                            cmd.entry_rd   = 1'b1;
                            cmd.tab_rd     = 1'b1;
                            cmd.tab_rd_src = TRD_REQ;
                            slot_sel_next  = SLOT_REQ;
                            off_sel_next   = OFF_TAB;
                            val_sel_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (stat.row_err || stat.col_err)
                        begin
                            res_status_next = STAT_RANGE;
                            state_next      = ST_FIN;
                        end
                        else
                        begin
                            cmd.idx_clr  = 1'b1;
                            off_sel_next = OFF_TRIP;
                            state_next   = ST_SRCH_RD;
                        end
                    end
                endcase
            end

            ST_SRCH_RD:
            begin
                if (stat.idx_at_count)
                begin
                    // Every registered offset is smaller: not found, slot is the end.
                    if (stat.func == FUNC_LOAD)
                    begin
                        res_status_next = STAT_NOREG;
                        state_next      = ST_FIN;
                    end
                    else if (stat.full)
                    begin
                        res_status_next = STAT_FULL;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        cmd.sh_load   = 1'b1;
                        slot_sel_next = SLOT_IDX;
                        state_next    = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    cmd.tab_rd     = 1'b1;
                    cmd.tab_rd_src = TRD_IDX;
                    state_next     = ST_SRCH_CMP;
                end
            end

            ST_SRCH_CMP:
            begin
                if (stat.tab_lt)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRCH_RD;
                end
                else if (stat.tab_eq)
                begin
                    slot_sel_next = SLOT_IDX;
                    if (stat.func == FUNC_LOAD)
                    begin
                        cmd.vw_rd  = 1'b1;
                        state_next = ST_LOAD_WR;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else if (stat.func == FUNC_LOAD)
                begin
                    res_status_next = STAT_NOREG;
                    state_next      = ST_FIN;
                end
                else if (stat.full)
                begin
                    res_status_next = STAT_FULL;
                    state_next      = ST_FIN;
                end
                else
                begin
                    cmd.sh_load   = 1'b1;
                    slot_sel_next = SLOT_IDX;
                    state_next    = ST_SHIFT_RD;
                end
            end

            ST_SHIFT_RD:
            begin
                if (stat.sh_at_idx)
                begin
                    cmd.tab_wr     = 1'b1;
                    cmd.tab_wr_src = TWR_INSERT;
                    cmd.cnt_inc    = 1'b1;
                    state_next     = ST_FIN;
                end
                else
                begin
                    cmd.tab_rd     = 1'b1;
                    cmd.tab_rd_src = TRD_SHIFT;
                    state_next     = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                cmd.tab_wr     = 1'b1;
                cmd.tab_wr_src = TWR_SHIFT;
                cmd.sh_dec     = 1'b1;
                state_next     = ST_SHIFT_RD;
            end

            ST_LOAD_WR:
            begin
                cmd.ld_wr  = 1'b1;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            res_status_reg <= STAT_OK;
            slot_sel_reg   <= SLOT_ZERO;
            off_sel_reg    <= OFF_ZERO;
            val_sel_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            slot_sel_reg   <= slot_sel_next;
            off_sel_reg    <= off_sel_next;
            val_sel_reg    <= val_sel_next;
        end
    end

endmodule

>>> rtl/cds_datapath.sv
// Datapath of the diagonal storage converter: item registers, sorted offset
// table, value store, valid marks and the result register. Uses cds_pkg.
module cds_datapath
    import cds_pkg::*;
#(
    parameter int MAX_DIM   = 64,
    parameter int MAX_DIAGS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output stat_t                        stat,
    input  logic [FUNC_W-1:0]            func,
    input  logic [ROW_W-1:0]             row_index,
    input  logic [COL_W-1:0]             col_index,
    input  logic [VALUE_W-1:0]           value_bits,
    input  logic [SLOT_W-1:0]            slot,
    input  logic [DIM_W-1:0]             num_rows,
    input  logic [DIM_W-1:0]             num_cols,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [STATUS_W-1:0]          status,
    output logic [SLOT_W-1:0]            slot_index,
    output logic signed [OFF_W-1:0]      diag_offset,
    output logic [VALUE_W-1:0]           value_out,
    output logic [COUNT_W-1:0]           diag_count,
    output logic [DIM_W-1:0]             max_diag_length
);

    localparam int SW    = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1;
    localparam int CW    = $clog2(MAX_DIAGS + 1);
    localparam int RW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIAGS * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    // Item registers.
    func_t                  func_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [SLOT_W-1:0]      req_slot_reg;
    logic signed [OFF_W-1:0] off_reg;

    // Control state.
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          sh_reg;
    logic [MAX_DIAGS-1:0]   row_valid_reg;

    // Memories and their read registers.
    logic signed [OFF_W-1:0] tmem [MAX_DIAGS];
    logic [MAX_DIM-1:0]      vmem [MAX_DIAGS];
    logic [VALUE_W-1:0]      vstore [DEPTH];
    logic signed [OFF_W-1:0] tab_rd_reg;
    logic [MAX_DIM-1:0]      vword_reg;
    logic                    vok_reg;
    logic [VALUE_W-1:0]      val_rd_reg;

    logic                    out_valid_reg;
    logic [DIM_W-1:0]        rows_eff;
    logic [DIM_W-1:0]        cols_eff;
    logic [CW-1:0]           sh_m1;
    logic [SW-1:0]           req_sl;
    logic [SW-1:0]           idx_sl;
    logic [SW-1:0]           tab_raddr;
    logic [SW-1:0]           tab_waddr;
    logic signed [OFF_W-1:0] tab_wdata;
    logic [SW-1:0]           vw_raddr;
    logic [RW-1:0]           row_sel;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [MAX_DIM-1:0]      row_bit;
    logic [MAX_DIM-1:0]      vword_new;

    // Register values outside 1..MAX_DIM are clamped into that range.
    always_comb
    begin
        if (num_rows == '0)
            rows_eff = DIM_W'(1);
        else if (11'(num_rows) > 11'(MAX_DIM))
            rows_eff = DIM_W'(MAX_DIM);
        else
            rows_eff = num_rows;

        if (num_cols == '0)
            cols_eff = DIM_W'(1);
        else if (11'(num_cols) > 11'(MAX_DIM))
            cols_eff = DIM_W'(MAX_DIM);
        else
            cols_eff = num_cols;
    end

    assign sh_m1   = sh_reg - CW'(1);
    assign req_sl  = SW'(req_slot_reg);
    assign idx_sl  = idx_reg[SW-1:0];
    assign row_sel = RW'(row_reg);
    assign rd_addr = AW'(req_sl) * AW'(MAX_DIM) + AW'(row_reg);
    assign wr_addr = AW'(idx_sl) * AW'(MAX_DIM) + AW'(row_reg);
    assign row_bit = {{(MAX_DIM - 1){1'b0}}, 1'b1} << row_sel;
    assign vword_new = (vok_reg ? vword_reg : '0) | row_bit;
    assign vw_raddr  = cmd.vw_rd ? idx_sl : req_sl;

    always_comb
    begin
        case (cmd.tab_rd_src)
            TRD_IDX:   tab_raddr = idx_sl;
            TRD_SHIFT: tab_raddr = sh_m1[SW-1:0];
            TRD_REQ:   tab_raddr = req_sl;
            default:   tab_raddr = idx_sl;
        endcase
        if (cmd.tab_wr_src == TWR_INSERT)
        begin
            tab_waddr = idx_sl;
            tab_wdata = off_reg;
        end
        else
        begin
            tab_waddr = sh_reg[SW-1:0];
            tab_wdata = tab_rd_reg;
        end
    end

    // Status toward the sequencer.
    always_comb
    begin
        stat.func         = func_reg;
        stat.row_err      = {1'b0, row_reg} >= rows_eff;
        stat.col_err      = {1'b0, col_reg} >= cols_eff;
        stat.req_bad      = (8'(req_slot_reg) >= 8'(count_reg))
                         || (8'(req_slot_reg) >= 8'(MAX_DIAGS));
        stat.full         = 8'(count_reg) >= 8'(MAX_DIAGS);
        stat.idx_at_count = idx_reg == count_reg;
        stat.sh_at_idx    = sh_reg == idx_reg;
        stat.tab_lt       = tab_rd_reg < off_reg;
        stat.tab_eq       = tab_rd_reg == off_reg;
        stat.out_busy     = out_valid_reg && !out_ready;
    end

    // Item registers; the diagonal offset is formed once at acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            func_reg     <= func_t'(func);
            row_reg      <= row_index;
            col_reg      <= col_index;
            value_reg    <= value_bits;
            req_slot_reg <= slot;
            off_reg      <= signed'({1'b0, col_index}) - signed'({1'b0, row_index});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            sh_reg        <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.cnt_inc)
                count_reg <= count_reg + CW'(1);

            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + CW'(1);

            if (cmd.sh_load)
                sh_reg <= count_reg;
            else if (cmd.sh_dec)
                sh_reg <= sh_m1;

            // All slot rows of valid marks are dropped at once on clear.
            if (cmd.clear)
                row_valid_reg <= '0;
            else if (cmd.ld_wr)
                row_valid_reg[idx_sl] <= 1'b1;

            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tab_wr)
            tmem[tab_waddr] <= tab_wdata;
        if (cmd.tab_rd)
            tab_rd_reg <= tmem[tab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_wr)
            vmem[idx_sl] <= vword_new;
        if (cmd.vw_rd || cmd.entry_rd)
        begin
            vword_reg <= vmem[vw_raddr];
            vok_reg   <= row_valid_reg[vw_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_wr)
            vstore[wr_addr] <= value_reg;
        if (cmd.entry_rd)
            val_rd_reg <= vstore[rd_addr];
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status <= cmd.res_status;
            case (cmd.slot_sel)
                SLOT_REQ: slot_index <= req_slot_reg;
                SLOT_IDX: slot_index <= SLOT_W'(idx_reg);
                default:  slot_index <= '0;
            endcase
            case (cmd.off_sel)
                OFF_TRIP: diag_offset <= off_reg;
                OFF_TAB:  diag_offset <= tab_rd_reg;
                default:  diag_offset <= '0;
            endcase
            value_out <= (cmd.val_sel && vok_reg && vword_reg[row_sel]) ? val_rd_reg : '0;
            diag_count      <= COUNT_W'(count_reg);
            max_diag_length <= (rows_eff < cols_eff) ? rows_eff : cols_eff;
        end
    end

    assign out_valid = out_valid_reg;

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tab_wr && cmd.tab_wr_src == TWR_INSERT) |-> (8'(count_reg) < 8'(MAX_DIAGS)))
        else $error("offset inserted into a full table");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |=> (count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("offset count did not advance by one");

    a_store_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_wr |-> (idx_reg < count_reg))
        else $error("value stored into an unregistered slot");

    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while stalled");

endmodule

>>> rtl/coo_to_diagonal_storage.sv
// Top level of the COO to compressed diagonal storage converter.
// Holds the configuration registers and joins cds_ctrl and cds_datapath (cds_pkg).
//
// Items arrive on the s_* stream; each transfer carries one command in s_tuser
// (scan, load, read or clear) and a triplet or read address in s_tdata. Exactly one
// result transfer leaves on the m_* stream for every input transfer, in order, with
// the status code in m_tuser. The cfg_* channel writes num_rows (index 0) and
// num_cols (index 1); it is always ready and is meant to be used only while idle.
// Items are handled one at a time, so the next input transfer can follow in the
// cycle after the result is loaded. Read, clear and out-of-range items go from the
// decode step straight to the final step that loads the result; a scan or load
// walks the sorted offset table one entry at a time (one table memory read, one
// compare), and inserting a new offset moves the entries above it up one at a
// time, each with one table read and one table write.
// Reset empties the offset table and all valid marks at once: valid marks are kept
// per slot row in flip-flops, so no clearing pass is needed and items are taken
// right after reset. When the receiver stalls, the result stays in the output
// register and the next item is still taken; it waits at its final step until the
// output register frees.
module coo_to_diagonal_storage
    import cds_pkg::*;
#(
    parameter int MAX_DIM   = 64,
    parameter int MAX_DIAGS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: row_index[5:0], col_index[11:6], value_bits[75:12],
    // slot[79:76].
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser from bit 0: func[1:0].
    input  logic [FUNC_W-1:0]     s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: slot_index[3:0], diag_offset[10:4], value_out[74:11],
    // diag_count[79:75], max_diag_length[86:80], zero[87].
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser from bit 0: status[1:0].
    output logic [STATUS_W-1:0]   m_tuser,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data
);

    logic [DIM_W-1:0]     num_rows_reg;
    logic [DIM_W-1:0]     num_cols_reg;
    cmd_t                 cmd;
    stat_t                stat;
    logic [SLOT_W-1:0]    slot_index;
    logic signed [OFF_W-1:0] diag_offset;
    logic [VALUE_W-1:0]   value_out;
    logic [COUNT_W-1:0]   diag_count;
    logic [DIM_W-1:0]     max_diag_length;

    assign cfg_ready = 1'b1;

    // Configuration registers; both reset to the full 64 x 64 matrix.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= DIM_W'(64);
            num_cols_reg <= DIM_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                CFG_NUM_COLS: num_cols_reg <= cfg_data;
                default:      num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    cds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cds_datapath #(
        .MAX_DIM   (MAX_DIM),
        .MAX_DIAGS (MAX_DIAGS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .func            (s_tuser),
        .row_index       (s_tdata[5:0]),
        .col_index       (s_tdata[11:6]),
        .value_bits      (s_tdata[75:12]),
        .slot            (s_tdata[79:76]),
        .num_rows        (num_rows_reg),
        .num_cols        (num_cols_reg),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .status          (m_tuser),
        .slot_index      (slot_index),
        .diag_offset     (diag_offset),
        .value_out       (value_out),
        .diag_count      (diag_count),
        .max_diag_length (max_diag_length)
    );

    assign m_tdata = {1'b0, max_diag_length, diag_count, value_out,
                      diag_offset, slot_index};

endmodule

>>> tb/cds_checker.sv
`timescale 1ns / 100ps
// Scoreboard for coo_to_diagonal_storage: watches the input, result and configuration
// channels, predicts every result and compares it field by field. Uses cds_pkg.
module cds_checker
    import cds_pkg::*;
#(
    parameter int MAX_DIM   = 64,
    parameter int MAX_DIAGS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]    s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]  m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output int                   pending,
    output int                   mismatches
);

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [OFF_W-1:0]     offset;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
        logic [DIM_W-1:0]     diag_len;
    } diag_result_t;

    diag_result_t            expected_q[$];
    logic [DIM_W-1:0]        rows_reg;
    logic [DIM_W-1:0]        cols_reg;
    logic signed [OFF_W-1:0] offsets[MAX_DIAGS];
    int                      n_offsets;
    logic [VALUE_W-1:0]      diag_values[MAX_DIAGS*MAX_DIM];
    logic                    diag_filled[MAX_DIAGS*MAX_DIM];
    int                      err_count = 0;

    assign mismatches = err_count;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // Predicts the result of one item and updates the table and value store.
    function automatic diag_result_t convert_item(func_t op, int r, int c,
                                                  logic [VALUE_W-1:0] v, int rs);
        diag_result_t res;
        int           rows;
        int           cols;
        int           off;
        int           pos;
        int           addr;
        int           i;
        logic         found;
        res  = '0;
        rows = clamp_dim(rows_reg);
        cols = clamp_dim(cols_reg);
        off  = c - r;
        if (op == FUNC_CLEAR) begin
            n_offsets = 0;
            for (i = 0; i < MAX_DIAGS * MAX_DIM; i++)
                diag_filled[i] = 1'b0;
        end else if (op == FUNC_READ) begin
            if (r >= rows) begin
                res.status = STAT_RANGE;
            end else if (rs >= n_offsets) begin
                res.status = STAT_NOREG;
                res.slot   = rs[SLOT_W-1:0];
            end else begin
                addr       = rs * MAX_DIM + r;
                res.slot   = rs[SLOT_W-1:0];
                res.offset = offsets[rs];
                if (diag_filled[addr])
                    res.value = diag_values[addr];
            end
        end else if (r >= rows || c >= cols) begin
            res.status = STAT_RANGE;
        end else begin
            res.offset = off[OFF_W-1:0];
            pos = 0;
            for (i = 0; i < n_offsets; i++)
                if (offsets[i] < off)
                    pos++;
            found = (pos < n_offsets) && (offsets[pos] == off);
            if (op == FUNC_SCAN) begin
                if (found) begin
                    res.slot = pos[SLOT_W-1:0];
                end else if (n_offsets >= MAX_DIAGS) begin
                    res.status = STAT_FULL;
                end else begin
                    for (i = n_offsets; i > pos; i--)
                        offsets[i] = offsets[i-1];
                    offsets[pos] = off[OFF_W-1:0];
                    n_offsets++;
                    res.slot = pos[SLOT_W-1:0];
                end
            end else if (found) begin
                addr              = pos * MAX_DIM + r;
                diag_values[addr] = v;
                diag_filled[addr] = 1'b1;
                res.slot          = pos[SLOT_W-1:0];
            end else begin
                res.status = STAT_NOREG;
            end
        end
        res.count    = n_offsets[COUNT_W-1:0];
        res.diag_len = (rows < cols) ? rows[DIM_W-1:0] : cols[DIM_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        diag_result_t want;
        int           i;
        if (!rst_n) begin
            rows_reg  = 7'd64;
            cols_reg  = 7'd64;
            n_offsets = 0;
            for (i = 0; i < MAX_DIAGS * MAX_DIM; i++)
                diag_filled[i] = 1'b0;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_NUM_ROWS)
                    rows_reg = cfg_data;
                else
                    cols_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(convert_item(func_t'(s_tuser), int'(s_tdata[5:0]),
                                                  int'(s_tdata[11:6]), s_tdata[75:12],
                                                  int'(s_tdata[79:76])));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata[74:11], '0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", VALUE_W'(m_tuser), VALUE_W'(want.status));
                    if (m_tdata[3:0] !== want.slot)
                        report_mismatch("slot_index", VALUE_W'(m_tdata[3:0]),
                                        VALUE_W'(want.slot));
                    if (m_tdata[10:4] !== want.offset)
                        report_mismatch("diag_offset", VALUE_W'(m_tdata[10:4]),
                                        VALUE_W'(want.offset));
                    if (m_tdata[74:11] !== want.value)
                        report_mismatch("value_out", m_tdata[74:11], want.value);
                    if (m_tdata[79:75] !== want.count)
                        report_mismatch("diag_count", VALUE_W'(m_tdata[79:75]),
                                        VALUE_W'(want.count));
                    if (m_tdata[86:80] !== want.diag_len)
                        report_mismatch("max_diag_length", VALUE_W'(m_tdata[86:80]),
                                        VALUE_W'(want.diag_len));
                    if (m_tdata[87] !== 1'b0)
                        report_mismatch("padding bit", VALUE_W'(m_tdata[87]), '0);
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

>>> tb/tb_coo_to_diagonal_storage.sv
`timescale 1ns / 100ps
// Top of the coo_to_diagonal_storage testbench: clock, reset, stimulus and verdict.
// Depends on cds_pkg, the block itself and the cds_checker scoreboard.
module tb_coo_to_diagonal_storage;
    import cds_pkg::*;

    localparam int MAX_DIM   = 64;
    localparam int MAX_DIAGS = 16;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = CFG_NUM_ROWS;
    logic [DIM_W-1:0]     cfg_data = '0;

    int pending;
    int mismatches;

    // When set, neither the sender nor the receiver inserts any idle cycles.
    logic quiet = 1'b0;
    int   rx_hold = 0;

    // Effective matrix size as the stimulus sees it, used to aim triplets in range.
    int dim_rows = 64;
    int dim_cols = 64;

    // Offsets registered since the last clear and rows that received a load.
    int known_offs[$];
    int loaded_rows[$];

    initial begin
        forever #5 clk = ~clk;
    end

    coo_to_diagonal_storage #(
        .MAX_DIM   (MAX_DIM),
        .MAX_DIAGS (MAX_DIAGS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cds_checker #(
        .MAX_DIM   (MAX_DIM),
        .MAX_DIAGS (MAX_DIAGS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    // Idle length for either side: mostly none or a short gap, now and then a long
    // stall that can outlast the slowest scan, so the block backs up behind it.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The receiver takes one result and then may hold off for a random stretch.
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            rx_hold  <= pick_gap();
        end
    end

    // Presents one item after an optional idle gap and waits for its transfer.
    // The valid is only lowered when a gap is taken, so back-to-back items keep it
    // high without a second assignment in the same step.
    task automatic send_item(func_t op, logic [5:0] row, logic [5:0] col,
                             logic [VALUE_W-1:0] value, logic [3:0] slot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {slot, value, col, row};
        do @(posedge clk); while (!s_tready);
    endtask

    // Lets the block run dry, then writes both size registers back to back. The first
    // edge is waited out so that the count of outstanding results includes the last
    // item sent.
    task automatic set_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NUM_ROWS;
        cfg_data  <= rows;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_NUM_COLS;
        cfg_data  <= cols;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // A zero size acts as one and anything above the maximum as the maximum.
        dim_rows = (rows == 0) ? 1 : ((rows > MAX_DIM) ? MAX_DIM : rows);
        dim_cols = (cols == 0) ? 1 : ((cols > MAX_DIM) ? MAX_DIM : cols);
    endtask

    // Chooses a triplet lying on diagonal off inside the current matrix. When the
    // diagonal does not cross the matrix any more, an arbitrary in-range triplet is
    // used instead.
    task automatic pick_on_diag(int off, output int row, output int col);
        int lo;
        int hi;
        lo = (off < 0) ? -off : 0;
        hi = (dim_rows - 1 < dim_cols - 1 - off) ? dim_rows - 1 : dim_cols - 1 - off;
        if (lo <= hi) begin
            row = $urandom_range(lo, hi);
            col = row + off;
        end else begin
            row = $urandom_range(0, dim_rows - 1);
            col = $urandom_range(0, dim_cols - 1);
        end
    endtask

    // One random item. Most items are well formed: scans that build up the table
    // (some of them repeats), loads aimed at registered diagonals, and reads aimed
    // at loaded rows and registered slots. The rest is occasional clears, which
    // let the table fill again from empty, and pure noise over all field values.
    task automatic issue_random_item();
        int                 roll;
        int                 row;
        int                 col;
        int                 off;
        int                 slot;
        int                 i;
        logic               seen;
        logic [VALUE_W-1:0] value;
        roll  = $urandom_range(0, 99);
        value = {$urandom, $urandom};
        if ($urandom_range(0, 19) == 0)
            value = $urandom_range(0, 1) ? '1 : '0;
        slot = $urandom_range(0, 15);
        if (roll < 8) begin
            send_item(func_t'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 63)),
                      COL_W'($urandom_range(0, 63)), value, SLOT_W'(slot));
        end else if (roll < 10) begin
            send_item(FUNC_CLEAR, ROW_W'($urandom_range(0, 63)),
                      COL_W'($urandom_range(0, 63)), value, SLOT_W'(slot));
            known_offs.delete();
            loaded_rows.delete();
        end else if (roll < 45) begin
            if (known_offs.size() > 0 && $urandom_range(0, 3) == 0) begin
                pick_on_diag(known_offs[$urandom_range(0, known_offs.size() - 1)], row, col);
            end else begin
                row = $urandom_range(0, dim_rows - 1);
                col = $urandom_range(0, dim_cols - 1);
            end
            send_item(FUNC_SCAN, ROW_W'(row), COL_W'(col), value, SLOT_W'(slot));
            // Only an in-range scan of a new offset with room left registers it.
            off  = col - row;
            seen = 1'b0;
            for (i = 0; i < known_offs.size(); i++)
                if (known_offs[i] == off)
                    seen = 1'b1;
            if (!seen && known_offs.size() < MAX_DIAGS && row < dim_rows && col < dim_cols)
                known_offs.push_back(off);
        end else if (roll < 75) begin
            if (known_offs.size() > 0 && $urandom_range(0, 9) != 0) begin
                pick_on_diag(known_offs[$urandom_range(0, known_offs.size() - 1)], row, col);
            end else begin
                row = $urandom_range(0, dim_rows - 1);
                col = $urandom_range(0, dim_cols - 1);
            end
            send_item(FUNC_LOAD, ROW_W'(row), COL_W'(col), value, SLOT_W'(slot));
            if (loaded_rows.size() < 32)
                loaded_rows.push_back(row);
            else
                loaded_rows[$urandom_range(0, 31)] = row;
        end else begin
            if (loaded_rows.size() > 0 && $urandom_range(0, 9) < 7)
                row = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
            else if ($urandom_range(0, 19) == 0)
                row = $urandom_range(0, 63);
            else
                row = $urandom_range(0, dim_rows - 1);
            if (known_offs.size() > 0 && $urandom_range(0, 19) < 17)
                slot = $urandom_range(0, known_offs.size() - 1);
            send_item(FUNC_READ, ROW_W'(row), COL_W'($urandom_range(0, 63)), value,
                      SLOT_W'(slot));
        end
    endtask

    // Sizes for the random phases, extremes included: a zero row or column count
    // and one above the maximum, a single cell, skewed shapes and the full matrix.
    int phase_rows[8] = '{64, 0, 127, 1, 17, 40, 64, 2};
    int phase_cols[8] = '{64, 127, 0, 1, 40, 17, 64, 64};

    initial begin
        int p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset size of 64 by 64. The table starts empty, so a
        // read hits an unregistered slot and a load finds no diagonal.
        send_item(FUNC_READ,  6'd0,  6'd0,  64'h0, 4'd0);
        send_item(FUNC_LOAD,  6'd0,  6'd0,  64'h1234_5678_9abc_def0, 4'd0);
        // Main diagonal and both extreme offsets, then a repeat of a known offset.
        send_item(FUNC_SCAN,  6'd0,  6'd0,  64'h0, 4'd15);
        send_item(FUNC_SCAN,  6'd0,  6'd63, 64'h0, 4'd0);
        send_item(FUNC_SCAN,  6'd63, 6'd0,  '1,    4'd0);
        send_item(FUNC_SCAN,  6'd7,  6'd7,  64'h0, 4'd0);
        // Loads with the value extremes and one ordinary pattern.
        send_item(FUNC_LOAD,  6'd0,  6'd63, '1,    4'd0);
        send_item(FUNC_LOAD,  6'd63, 6'd0,  64'h0, 4'd15);
        send_item(FUNC_LOAD,  6'd5,  6'd5,  64'ha5a5_5a5a_0ff0_f00f, 4'd0);
        // Reads of loaded entries, an entry never loaded and a slot past the count.
        send_item(FUNC_READ,  6'd5,  6'd0,  64'h0, 4'd1);
        send_item(FUNC_READ,  6'd0,  6'd63, 64'h0, 4'd2);
        send_item(FUNC_READ,  6'd63, 6'd0,  64'h0, 4'd0);
        send_item(FUNC_READ,  6'd6,  6'd0,  64'h0, 4'd1);
        send_item(FUNC_READ,  6'd0,  6'd0,  64'h0, 4'd15);
        // A clear empties both the table and the stored entries.
        send_item(FUNC_CLEAR, 6'd63, 6'd63, '1,    4'd15);
        send_item(FUNC_READ,  6'd5,  6'd0,  64'h0, 4'd0);
        send_item(FUNC_SCAN,  6'd5,  6'd5,  64'h0, 4'd0);
        send_item(FUNC_READ,  6'd5,  6'd0,  64'h0, 4'd0);

        // A small matrix, so that rows and columns can fall outside it.
        set_dims(7'd5, 7'd3);
        send_item(FUNC_SCAN,  6'd5,  6'd0,  64'h0, 4'd0);
        send_item(FUNC_SCAN,  6'd0,  6'd3,  64'h0, 4'd0);
        send_item(FUNC_LOAD,  6'd63, 6'd63, '1,    4'd0);
        send_item(FUNC_READ,  6'd5,  6'd0,  64'h0, 4'd0);
        send_item(FUNC_READ,  6'd4,  6'd0,  64'h0, 4'd0);
        known_offs.push_back(0);

        // Random phases, two of them with no idle cycles on either side.
        for (p = 0; p < 8; p++) begin
            set_dims(DIM_W'(phase_rows[p]), DIM_W'(phase_cols[p]));
            quiet <= (p == 3 || p == 6);
            repeat (75) issue_random_item();
        end

        // Wait for every outstanding result, then give the block time to show any
        // stray transfer before the verdict.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
